FILE: rtl/smpd_pkg.sv
// ----------------------------------------------------------------------------
// smpd_pkg
// Shared types and constants of the serial mouse packet decoder.
// ----------------------------------------------------------------------------
package smpd_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 15;

  localparam int QUEUE_DEPTH_DEF = 2;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_PROTOCOL  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_X     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_Y     = 3'd4;

  // protocol codes
  localparam logic [2:0] PROTO_MS3   = 3'd0;
  localparam logic [2:0] PROTO_MSC5  = 3'd1;
  localparam logic [2:0] PROTO_MM    = 3'd2;
  localparam logic [2:0] PROTO_LOGI  = 3'd3;
  localparam logic [2:0] PROTO_BUS   = 3'd4;

  // event kinds
  localparam logic [1:0] EV_MOVE = 2'd0;
  localparam logic [1:0] EV_DRAG = 2'd1;
  localparam logic [1:0] EV_DOWN = 2'd2;
  localparam logic [1:0] EV_UP   = 2'd3;

  localparam logic [14:0] MAX_RESET       = 15'd32767;
  localparam logic [14:0] CURSOR_RESET    = 15'd16383;
  localparam logic [8:0]  THRESHOLD_RESET = 9'd25;
  localparam logic [3:0]  GAIN_RESET      = 4'd2;

  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

  // one decoded packet: buttons and raw signed motion
  typedef struct packed {
    logic [2:0] btn;
    logic [7:0] dx;
    logic [7:0] dy;
  } pkt_t;

endpackage

FILE: rtl/smpd_front.sv
// ----------------------------------------------------------------------------
// smpd_front
// Byte framing: header hunt, data collection and per-protocol packet decode.
// ----------------------------------------------------------------------------
module smpd_front
  import smpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_wr_t    cfg,
  input  logic       in_valid,
  input  logic       in_hold,
  input  logic [7:0] rx_byte,
  output logic       pkt_valid,
  output pkt_t       pkt
);

  logic [2:0] protocol;
  logic [2:0] proto_eff;
  logic [7:0] header_byte;
  logic [7:0] data_bytes [4];
  logic [2:0] byte_index;
  logic [2:0] byte_index_next;

  logic       accept;
  logic [7:0] hdr_mask;
  logic [7:0] hdr_id;
  logic [7:0] dat_mask;
  logic [2:0] dat_count;
  logic       is_header;
  logic       is_bad;
  logic       done;
  logic [1:0] wsel;
  logic [7:0] d [4];
  logic [7:0] sum13;
  logic [7:0] sum24;

  assign accept    = in_valid && !in_hold;
  assign proto_eff = (protocol > PROTO_BUS) ? PROTO_MS3 : protocol;

  always_comb begin
    case (proto_eff)
      PROTO_MSC5, PROTO_BUS: begin
        hdr_mask  = 8'hf8;
        hdr_id    = 8'h80;
        dat_mask  = 8'h00;
        dat_count = 3'd4;
      end
      PROTO_MM, PROTO_LOGI: begin
        hdr_mask  = 8'he0;
        hdr_id    = 8'h80;
        dat_mask  = 8'h80;
        dat_count = 3'd2;
      end
      default: begin
        hdr_mask  = 8'h40;
        hdr_id    = 8'h40;
        dat_mask  = 8'h40;
        dat_count = 3'd2;
      end
    endcase
  end

  assign is_header = (rx_byte & hdr_mask) == hdr_id;
  assign is_bad    = ((rx_byte & dat_mask) != 8'h00) || (rx_byte == 8'h80);
  assign wsel      = byte_index[1:0] - 2'd1;
  // the packet completes once the collected count reaches the protocol's count
  assign done      = (byte_index != 3'd0) && !is_bad && (byte_index >= dat_count);

  always_comb begin
    byte_index_next = byte_index;
    if (byte_index == 3'd0) begin
      if (is_header) byte_index_next = 3'd1;
    end else if (is_bad) begin
      byte_index_next = 3'd1;
    end else if (done) begin
      byte_index_next = 3'd0;
    end else begin
      byte_index_next = byte_index + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol    <= PROTO_MS3;
      header_byte <= 8'h00;
      byte_index  <= 3'd0;
    end else begin
      if (cfg.we && cfg.index == CFG_PROTOCOL) protocol <= cfg.data[2:0];
      if (accept) begin
        byte_index <= byte_index_next;
        if (byte_index == 3'd0 && is_header) header_byte <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_index != 3'd0 && !is_bad) data_bytes[wsel] <= rx_byte;
  end

  // packet bytes with the byte now arriving merged in
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      d[k] = (wsel == 2'(k)) ? rx_byte : data_bytes[k];
    end
  end

  assign sum13 = d[0] + d[2];
  assign sum24 = d[1] + d[3];

  always_comb begin
    case (proto_eff)
      PROTO_MSC5: begin
        pkt.btn = ~header_byte[2:0];
        pkt.dx  = sum13;
        pkt.dy  = 8'h00 - sum24;
      end
      PROTO_MM, PROTO_LOGI: begin
        pkt.btn = header_byte[2:0];
        pkt.dx  = header_byte[4] ? d[0] : 8'h00 - d[0];
        pkt.dy  = header_byte[3] ? 8'h00 - d[1] : d[1];
      end
      PROTO_BUS: begin
        pkt.btn = ~header_byte[2:0];
        pkt.dx  = d[0];
        pkt.dy  = 8'h00 - d[1];
      end
      default: begin
        pkt.btn = {header_byte[5], 1'b0, header_byte[4]};
        pkt.dx  = {header_byte[1:0], d[0][5:0]};
        pkt.dy  = {header_byte[3:2], d[1][5:0]};
      end
    endcase
  end

  assign pkt_valid = accept && done;

endmodule

FILE: rtl/smpd_queue.sv
// ----------------------------------------------------------------------------
// smpd_queue
// Short packet queue between the framing front and the motion back end.
// ----------------------------------------------------------------------------
module smpd_queue
  import smpd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  pkt_t push_data,
  output logic full,
  output logic pop_valid,
  input  logic pop_stall,
  output pkt_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pkt_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign full      = count == CW'(DEPTH);
  assign pop_valid = count != '0;
  assign pop       = pop_valid && !pop_stall;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/smpd_back.sv
// ----------------------------------------------------------------------------
// smpd_back
// Motion back end: acceleration, cursor accumulation with clamp, event class.
// ----------------------------------------------------------------------------
module smpd_back
  import smpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_wr_t      cfg,
  input  logic         pkt_valid,
  output logic         pkt_stall,
  input  pkt_t         pkt,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [2:0]   buttons,
  output logic [11:0]  delta_x,
  output logic [11:0]  delta_y,
  output logic [14:0]  pos_x,
  output logic [14:0]  pos_y,
  output logic [1:0]   event_kind
);

  logic [8:0]  accel_threshold;
  logic [3:0]  accel_gain;
  logic [14:0] max_x;
  logic [14:0] max_y;
  logic [14:0] cursor_x;
  logic [14:0] cursor_y;

  // motion stage
  logic        a_valid;
  logic [2:0]  a_btn;
  logic [11:0] a_mx;
  logic [11:0] a_my;
  logic [1:0]  a_kind;

  logic        out_take;
  logic        a_move;
  logic        a_load;
  logic        pop;

  logic [7:0]  abs_x;
  logic [7:0]  abs_y;
  logic [8:0]  abs_sum;
  logic [3:0]  factor;
  logic signed [12:0] prod_x;
  logic signed [12:0] prod_y;
  logic [1:0]  kind;

  logic signed [16:0] sum_x;
  logic signed [16:0] sum_y;
  logic [14:0] cursor_x_next;
  logic [14:0] cursor_y_next;

  assign out_take  = !out_valid || !out_stall;
  assign a_move    = a_valid && out_take;
  assign a_load    = !a_valid || a_move;
  assign pkt_stall = !a_load;
  assign pop       = pkt_valid && a_load;

  assign abs_x   = pkt.dx[7] ? 8'h00 - pkt.dx : pkt.dx;
  assign abs_y   = pkt.dy[7] ? 8'h00 - pkt.dy : pkt.dy;
  assign abs_sum = {1'b0, abs_x} + {1'b0, abs_y};
  assign factor  = (abs_sum > accel_threshold) ? accel_gain : 4'd1;
  assign prod_x  = $signed(pkt.dx) * $signed({1'b0, factor});
  assign prod_y  = $signed(pkt.dy) * $signed({1'b0, factor});

  // class follows the raw motion, before gain
  always_comb begin
    if (pkt.dx != 8'h00 || pkt.dy != 8'h00) begin
      kind = (pkt.btn != 3'd0) ? EV_DRAG : EV_MOVE;
    end else begin
      kind = (pkt.btn != 3'd0) ? EV_DOWN : EV_UP;
    end
  end

  assign sum_x = $signed({2'b00, cursor_x}) + $signed({{5{a_mx[11]}}, a_mx});
  assign sum_y = $signed({2'b00, cursor_y}) + $signed({{5{a_my[11]}}, a_my});

  always_comb begin
    if (sum_x[16]) begin
      cursor_x_next = 15'd0;
    end else if (sum_x[15:0] > {1'b0, max_x}) begin
      cursor_x_next = max_x;
    end else begin
      cursor_x_next = sum_x[14:0];
    end
    if (sum_y[16]) begin
      cursor_y_next = 15'd0;
    end else if (sum_y[15:0] > {1'b0, max_y}) begin
      cursor_y_next = max_y;
    end else begin
      cursor_y_next = sum_y[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_threshold <= THRESHOLD_RESET;
      accel_gain      <= GAIN_RESET;
      max_x           <= MAX_RESET;
      max_y           <= MAX_RESET;
      cursor_x        <= CURSOR_RESET;
      cursor_y        <= CURSOR_RESET;
    end else begin
      if (a_move) begin
        cursor_x <= cursor_x_next;
        cursor_y <= cursor_y_next;
      end
      if (cfg.we) begin
        case (cfg.index)
          CFG_THRESHOLD: accel_threshold <= cfg.data[8:0];
          CFG_GAIN:      accel_gain <= cfg.data[3:0];
          CFG_MAX_X: begin
            max_x    <= cfg.data;
            cursor_x <= cfg.data >> 1;  // recenter
          end
          CFG_MAX_Y: begin
            max_y    <= cfg.data;
            cursor_y <= cfg.data >> 1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop)         a_valid <= 1'b1;
      else if (a_move) a_valid <= 1'b0;
      if (a_move)                      out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_btn  <= pkt.btn;
      a_mx   <= prod_x[11:0];
      a_my   <= prod_y[11:0];
      a_kind <= kind;
    end
    if (a_move) begin
      buttons    <= a_btn;
      delta_x    <= a_mx;
      delta_y    <= a_my;
      pos_x      <= cursor_x_next;
      pos_y      <= cursor_y_next;
      event_kind <= a_kind;
    end
  end

endmodule

FILE: rtl/serial_mouse_packet_decoder.sv
// ----------------------------------------------------------------------------
// serial_mouse_packet_decoder
// Frames received mouse bytes into packets and turns them into cursor events.
// ----------------------------------------------------------------------------
//  channel   handshake                payload
//  in        in_valid / in_stall      rx_byte
//  out       out_valid / out_stall    buttons, delta_x, delta_y, pos_x, pos_y,
//                                     event_kind
//  config    cfg_we                   cfg_index, cfg_data
//
// One byte is taken every cycle while the packet queue has room; in_stall
// rises whenever the queue is full, whether or not the back end stalls.
// A completing byte's event passes through the queue, the motion stage and
// the output register. The cursor add and clamp set the back end rate.
// Synchronous reset empties the queue and pipeline and restores registers.
// ----------------------------------------------------------------------------
module serial_mouse_packet_decoder
  import smpd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             rx_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             buttons,
  output logic [11:0]            delta_x,
  output logic [11:0]            delta_y,
  output logic [14:0]            pos_x,
  output logic [14:0]            pos_y,
  output logic [1:0]             event_kind
);

  cfg_wr_t cfg;
  logic    q_full;
  logic    push;
  pkt_t    push_data;
  logic    pop_valid;
  logic    pop_stall;
  pkt_t    pop_data;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;
  assign in_stall  = q_full;

  smpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_hold   (q_full),
    .rx_byte   (rx_byte),
    .pkt_valid (push),
    .pkt       (push_data)
  );

  smpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop_valid (pop_valid),
    .pop_stall (pop_stall),
    .pop_data  (pop_data)
  );

  smpd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pkt_valid  (pop_valid),
    .pkt_stall  (pop_stall),
    .pkt        (pop_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .buttons    (buttons),
    .delta_x    (delta_x),
    .delta_y    (delta_y),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .event_kind (event_kind)
  );

endmodule

FILE: tb/serial_mouse_packet_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_mouse_packet_decoder_tb
// Feeds framed, broken and noise mouse bytes under every protocol and several
// register settings, predicts each packet event in a scoreboard and compares
// every result transfer field by field.
// ----------------------------------------------------------------------------
module serial_mouse_packet_decoder_tb
  import smpd_pkg::*;
();

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 16;
  localparam int BYTES_PER_SET = 80;
  localparam int SETS_PER_PASS = 8;

  typedef struct packed {
    logic [2:0]  buttons;
    logic [11:0] dx;
    logic [11:0] dy;
    logic [14:0] px;
    logic [14:0] py;
    logic [1:0]  kind;
  } mouse_event_t;

  class mouse_event_board;
    logic [2:0]   proto;
    logic [8:0]   thr;
    logic [3:0]   gain;
    logic [14:0]  lim_x;
    logic [14:0]  lim_y;
    logic [7:0]   hdr;
    logic [7:0]   dat[4];
    int unsigned  idx;
    int           cur_x;
    int           cur_y;
    mouse_event_t pending_events[$];
    int           errors;

    function new();
      proto  = PROTO_MS3;
      thr    = THRESHOLD_RESET;
      gain   = GAIN_RESET;
      lim_x  = MAX_RESET;
      lim_y  = MAX_RESET;
      hdr    = 8'h00;
      foreach (dat[i]) dat[i] = 8'h00;
      idx    = 0;
      cur_x  = int'(CURSOR_RESET);
      cur_y  = int'(CURSOR_RESET);
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] word);
      case (index)
        CFG_PROTOCOL:  proto = word[2:0];
        CFG_THRESHOLD: thr = word[8:0];
        CFG_GAIN:      gain = word[3:0];
        CFG_MAX_X: begin
          lim_x = word;
          cur_x = int'(lim_x) / 2;
        end
        CFG_MAX_Y: begin
          lim_y = word;
          cur_y = int'(lim_y) / 2;
        end
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    function void report(string field, int unsigned got, int unsigned want);
      $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, field, got, want);
      errors++;
    endfunction

    // frame one accepted byte and predict the event of a completed packet
    function void note_byte(logic [7:0] b);
      logic [2:0]   p;
      logic [7:0]   hmask;
      logic [7:0]   hid;
      logic [7:0]   dmask;
      int unsigned  need;
      logic [2:0]   btn;
      logic [7:0]   ux;
      logic [7:0]   uy;
      int           dx;
      int           dy;
      int           acc;
      int           mx;
      int           my;
      mouse_event_t e;
      p = (proto > PROTO_BUS) ? PROTO_MS3 : proto;
      case (p)
        PROTO_MSC5, PROTO_BUS: begin
          hmask = 8'hF8; hid = 8'h80; dmask = 8'h00; need = 4;
        end
        PROTO_MM, PROTO_LOGI: begin
          hmask = 8'hE0; hid = 8'h80; dmask = 8'h80; need = 2;
        end
        default: begin
          hmask = 8'h40; hid = 8'h40; dmask = 8'h40; need = 2;
        end
      endcase
      if (idx == 0) begin
        if ((b & hmask) == hid) begin
          hdr = b;
          idx = 1;
        end
        return;
      end
      // bad data byte: drop collected data, keep the header
      if ((b & dmask) != 8'h00 || b == 8'h80) begin
        idx = 1;
        return;
      end
      dat[(idx - 1) % 4] = b;
      idx++;
      if (idx - 1 < need) return;
      idx = 0;
      case (p)
        PROTO_MSC5: begin
          btn = ~hdr[2:0];
          ux  = 8'(dat[0] + dat[2]);
          uy  = 8'(8'h00 - 8'(dat[1] + dat[3]));
        end
        PROTO_MM, PROTO_LOGI: begin
          btn = hdr[2:0];
          ux  = hdr[4] ? dat[0] : 8'(8'h00 - dat[0]);
          uy  = hdr[3] ? 8'(8'h00 - dat[1]) : dat[1];
        end
        PROTO_BUS: begin
          btn = ~hdr[2:0];
          ux  = dat[0];
          uy  = 8'(8'h00 - dat[1]);
        end
        default: begin
          btn = {hdr[5], 1'b0, hdr[4]};
          ux  = {hdr[1:0], dat[0][5:0]};
          uy  = {hdr[3:2], dat[1][5:0]};
        end
      endcase
      dx  = int'($signed(ux));
      dy  = int'($signed(uy));
      acc = (((dx < 0) ? -dx : dx) + ((dy < 0) ? -dy : dy) > int'(thr)) ? int'(gain) : 1;
      mx  = dx * acc;
      my  = dy * acc;
      cur_x = cur_x + mx;
      if (cur_x < 0) cur_x = 0;
      else if (cur_x > int'(lim_x)) cur_x = int'(lim_x);
      cur_y = cur_y + my;
      if (cur_y < 0) cur_y = 0;
      else if (cur_y > int'(lim_y)) cur_y = int'(lim_y);
      e.buttons = btn;
      e.dx      = 12'(mx);
      e.dy      = 12'(my);
      e.px      = 15'(cur_x);
      e.py      = 15'(cur_y);
      if (dx != 0 || dy != 0) e.kind = (btn != 3'd0) ? EV_DRAG : EV_MOVE;
      else e.kind = (btn != 3'd0) ? EV_DOWN : EV_UP;
      pending_events.push_back(e);
    endfunction

    function void check_event(mouse_event_t got);
      mouse_event_t want;
      if (pending_events.size() == 0) begin
        report("unexpected event", 32'(got.kind), 0);
        return;
      end
      want = pending_events.pop_front();
      if (got.buttons != want.buttons)
        report("buttons", 32'(got.buttons), 32'(want.buttons));
      if (got.dx != want.dx) report("delta_x", 32'(got.dx), 32'(want.dx));
      if (got.dy != want.dy) report("delta_y", 32'(got.dy), 32'(want.dy));
      if (got.px != want.px) report("pos_x", 32'(got.px), 32'(want.px));
      if (got.py != want.py) report("pos_y", 32'(got.py), 32'(want.py));
      if (got.kind != want.kind) report("event_kind", 32'(got.kind), 32'(want.kind));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             rx_byte = 8'h00;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [2:0]             buttons;
  logic [11:0]            delta_x;
  logic [11:0]            delta_y;
  logic [14:0]            pos_x;
  logic [14:0]            pos_y;
  logic [1:0]             event_kind;

  int send_idle_pct = 36;
  int recv_idle_pct = 84;

  mouse_event_board board = new();

  serial_mouse_packet_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .buttons    (buttons),
    .delta_x    (delta_x),
    .delta_y    (delta_y),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .event_kind (event_kind)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_event({buttons, delta_x, delta_y, pos_x, pos_y, event_kind});
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    board.note_byte(b);
    @(negedge clk);
  endtask

  task automatic send_seq(logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // drain all events and let queued bytes run through before a register write
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // bits above the register width carry junk that the block must ignore
  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, int unsigned value, int w);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'(($urandom << w) | value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= word;
    board.set_reg(index, word);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [2:0] active_proto();
    return (board.proto > PROTO_BUS) ? PROTO_MS3 : board.proto;
  endfunction

  function automatic logic [7:0] rand_header();
    case (active_proto())
      PROTO_MSC5, PROTO_BUS: return 8'h80 | 8'($urandom_range(7));
      PROTO_MM, PROTO_LOGI:  return 8'h80 | 8'($urandom_range(31));
      default:               return 8'h40 | 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_data();
    logic [7:0] b;
    case (active_proto())
      PROTO_MSC5, PROTO_BUS: do b = 8'($urandom); while (b == 8'h80);
      PROTO_MM, PROTO_LOGI:  b = 8'($urandom) & 8'h7F;
      default:               do b = 8'($urandom) & 8'hBF; while (b == 8'h80);
    endcase
    return b;
  endfunction

  function automatic logic [7:0] rand_bad_data();
    if ($urandom_range(1) == 0) return 8'h80;
    case (active_proto())
      PROTO_MSC5, PROTO_BUS: return 8'h80;
      PROTO_MM, PROTO_LOGI:  return 8'h80 | 8'($urandom);
      default:               return 8'h40 | 8'($urandom);
    endcase
  endfunction

  task automatic send_packet(bit broken, output int count);
    int need;
    int k;
    need  = (active_proto() == PROTO_MSC5 || active_proto() == PROTO_BUS) ? 4 : 2;
    count = 1 + need;
    send_byte(rand_header());
    if (broken) begin
      k = $urandom_range(need - 1);
      repeat (k) send_byte(rand_data());
      send_byte(rand_bad_data());
      count += k + 1;
    end
    repeat (need) send_byte(rand_data());
  endtask

  function automatic int unsigned pick_max();
    case ($urandom_range(3))
      0:       return 32767;
      1:       return $urandom_range(64);
      default: return $urandom_range(32767);
    endcase
  endfunction

  task automatic apply_setting(int k);
    int unsigned thr_v;
    int unsigned gain_v;
    case ($urandom_range(3))
      0:       thr_v = 0;
      1:       thr_v = 511;
      default: thr_v = $urandom_range(160);
    endcase
    case ($urandom_range(3))
      0:       gain_v = 1;
      1:       gain_v = 15;
      2:       gain_v = $urandom_range(15);
      default: gain_v = $urandom_range(15, 1);
    endcase
    write_reg(CFG_PROTOCOL, k % 8, 3);
    write_reg(CFG_THRESHOLD, thr_v, 9);
    write_reg(CFG_GAIN, gain_v, 4);
    // leave the cursor alone now and then so it drifts into the clamps
    if (k == 0 || $urandom_range(1) == 1) begin
      write_reg(CFG_MAX_X, pick_max(), 15);
      write_reg(CFG_MAX_Y, pick_max(), 15);
    end
  endtask

  task automatic random_traffic(int target);
    int sent;
    int n;
    int r;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(99);
      if (r < 75) begin
        send_packet(1'b0, n);
        sent += n;
      end else if (r < 87) begin
        send_packet(1'b1, n);
        sent += n;
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] seq[$];
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default registers: noise, empty packet, buttons only, bad bytes, extreme motion
    seq = '{8'h00, 8'h40, 8'h00, 8'h00, 8'h70, 8'h00, 8'h00,
            8'h4F, 8'h3F, 8'h7F, 8'h80, 8'h3F, 8'h3F, 8'h7E, 8'h00, 8'h00};
    send_seq(seq);
    settle();
    // zero gain: motion cancels but the kind follows the raw motion
    write_reg(CFG_GAIN, 0, 4);
    write_reg(CFG_THRESHOLD, 0, 9);
    write_reg(CFG_PROTOCOL, 32'(PROTO_MM), 3);
    seq = '{8'h9F, 8'h7F, 8'h7F};
    send_seq(seq);
    settle();
    // sums that wrap to -128, scaled by the largest gain against a zero clamp
    write_reg(CFG_GAIN, 15, 4);
    write_reg(CFG_PROTOCOL, 32'(PROTO_MSC5), 3);
    write_reg(CFG_MAX_X, 0, 15);
    seq = '{8'h80, 8'h7F, 8'h7F, 8'h01, 8'h01, 8'h80, 8'h01};
    send_seq(seq);
    settle();
    // switch framing mid-packet: two data bytes now complete it
    write_reg(CFG_PROTOCOL, 32'(PROTO_MS3), 3);
    send_byte(8'h02);
    settle();
    write_reg(CFG_PROTOCOL, 32'(PROTO_BUS), 3);
    write_reg(CFG_MAX_X, 32767, 15);
    write_reg(CFG_MAX_Y, 0, 15);
    seq = '{8'h87, 8'h7F, 8'h81, 8'h00, 8'h00};
    send_seq(seq);
    settle();

    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < SETS_PER_PASS; k++) begin
        settle();
        apply_setting(k);
        random_traffic(BYTES_PER_SET);
      end
    end

    settle();
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/smpd_pkg.sv
rtl/smpd_front.sv
rtl/smpd_queue.sv
rtl/smpd_back.sv
rtl/serial_mouse_packet_decoder.sv
tb/serial_mouse_packet_decoder_tb.sv
